>>> rtl/m4i_pkg.sv
// m4i_pkg: shared types, constants and helper functions for the 4x4 matrix
// inverse block. No dependencies.
package m4i_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ELEMS     = 16;
	localparam int QDEPTH    = 2;
	localparam int NUMW      = 64 + FRAC_BITS;
	localparam int CNTW      = $clog2(NUMW);

	localparam logic [3:0]  LAST_IDX  = 4'd15;
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] POS_LIM   = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIM   = 32'h8000_0000;

	typedef logic [3:0] idx_t;
	typedef logic [ELEMS-1:0][31:0] mat_t;

	// front to queue write request
	typedef struct packed {
		logic push;
		mat_t mat;
	} q_wr_t;

	// Column position (within the 3x3 minor) of factor f of triple term t.
	// Terms 0..2 are the positive diagonals, 3..5 the negative ones.
	function automatic logic [1:0] term_col(input logic [2:0] t, input logic [1:0] f);
		logic [1:0] y;
		y = 2'd0;
		case (t)
			3'd0: y = f;
			3'd1: y = (f == 2'd0) ? 2'd1 : (f == 2'd1) ? 2'd2 : 2'd0;
			3'd2: y = (f == 2'd0) ? 2'd2 : (f == 2'd1) ? 2'd0 : 2'd1;
			3'd3: y = (f == 2'd0) ? 2'd2 : (f == 2'd1) ? 2'd1 : 2'd0;
			3'd4: y = (f == 2'd0) ? 2'd0 : (f == 2'd1) ? 2'd2 : 2'd1;
			3'd5: y = (f == 2'd0) ? 2'd1 : (f == 2'd1) ? 2'd0 : 2'd2;
			default: y = 2'd0;
		endcase
		return y;
	endfunction

	// Matrix address of factor f of term t for adjugate entry ent = {r, c}:
	// the minor drops row c and column r.
	function automatic idx_t elem_addr(input idx_t ent, input logic [2:0] t,
			input logic [1:0] f);
		logic [1:0] y;
		logic [1:0] row;
		logic [1:0] col;
		y = term_col(t, f);
		row = (f < ent[1:0]) ? f : f + 2'd1;
		col = (y < ent[3:2]) ? y : y + 2'd1;
		return {row, col};
	endfunction

endpackage

>>> rtl/m4i_if.sv
// m4i_if: valid/ready channel interfaces for matrix elements in and results out.
// Depends on nothing.
interface m4i_elem_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  elem_index;
	logic signed [31:0] elem_value;

	modport source (output valid, elem_index, elem_value, input ready);
	modport sink (input valid, elem_index, elem_value, output ready);
endinterface

interface m4i_res_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  out_index;
	logic signed [31:0] out_value;
	logic               singular;
	logic               saturated;
	logic               last;

	modport source (output valid, out_index, out_value, singular, saturated, last,
		input ready);
	modport sink (input valid, out_index, out_value, singular, saturated, last,
		output ready);
endinterface

>>> rtl/m4i_front.sv
// m4i_front: accepts matrix elements, keeps the element store and queues a
// snapshot of the matrix on the last element. Depends on m4i_pkg, m4i_if.
module m4i_front (
	input  logic               clk,
	m4i_elem_if.sink           elem,
	output m4i_pkg::q_wr_t     wr,
	input  logic               full
);

	m4i_pkg::mat_t mat_q;
	logic          accept;

	assign elem.ready = !full;
	assign accept     = elem.valid && elem.ready;

	// element store, stale entries kept across matrices
	always_ff @(posedge clk) begin
		if (accept) begin
			mat_q[elem.elem_index] <= elem.elem_value;
		end
	end

	// snapshot including the element arriving now
	always_comb begin
		wr.push = accept && (elem.elem_index == m4i_pkg::LAST_IDX);
		for (int k = 0; k < m4i_pkg::ELEMS; k++) begin
			wr.mat[k] = (elem.elem_index == 4'(k)) ? elem.elem_value : mat_q[k];
		end
	end

endmodule

>>> rtl/m4i_queue.sv
// m4i_queue: short FIFO of matrix snapshots between front and back.
// Depends on m4i_pkg.
module m4i_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  m4i_pkg::q_wr_t  wr,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output m4i_pkg::mat_t   rd_data
);

	localparam int PW = (m4i_pkg::QDEPTH > 1) ? $clog2(m4i_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(m4i_pkg::QDEPTH + 1);

	m4i_pkg::mat_t mem [m4i_pkg::QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(m4i_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = wr.push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wr.mat;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(m4i_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(m4i_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/m4i_back.sv
// m4i_back: adjugate, determinant and per-element division on one shared
// 33x33 multiplier and a bit-serial divider; drives the result channel.
// Depends on m4i_pkg, m4i_if.
module m4i_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  m4i_pkg::mat_t  rd_data,
	output logic           pop,
	m4i_res_if.source      res
);

	localparam int F    = m4i_pkg::FRAC_BITS;
	localparam int NUMW = m4i_pkg::NUMW;
	localparam int CNTW = m4i_pkg::CNTW;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_TERM = 8'b0000_0010,
		ST_RND1 = 8'b0000_0100,
		ST_RND2 = 8'b0000_1000,
		ST_DET  = 8'b0001_0000,
		ST_DIVI = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t               state_q;
	m4i_pkg::mat_t        mat_q;
	logic signed [63:0]   cof_q [m4i_pkg::ELEMS];
	logic [m4i_pkg::ELEMS-1:0] csat_q;
	logic signed [63:0]   det_q;
	logic                 dsat_q;
	logic signed [127:0]  acc_q;
	logic [127:0]         mag_q;
	logic                 neg_q;
	logic                 detm_q;
	m4i_pkg::idx_t        ent_q;
	logic [2:0]           term_q;
	logic [2:0]           ph_q;
	logic [1:0]           j_q;
	logic signed [63:0]   mul_q;
	logic signed [63:0]   pab_q;
	logic [NUMW-1:0]      num_q;
	logic [63:0]          rem_q;
	logic [63:0]          den_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 qneg_q;

	logic                 ovalid_q;
	m4i_pkg::idx_t        oidx_q;
	logic [31:0]          oval_q;
	logic                 osing_q;
	logic                 osat_q;
	logic                 olast_q;

	logic signed [32:0]   mul_a;
	logic signed [32:0]   mul_b;
	logic signed [65:0]   prod;
	logic [31:0]          fa;
	logic [31:0]          fb;
	logic [31:0]          fc;
	logic [31:0]          mrow;
	logic [63:0]          cof_j;
	logic                 sub;
	logic signed [127:0]  addend;
	logic signed [127:0]  acc_nx;
	logic [127:0]         rnd_t;
	logic [127:0]         rnd_sh;
	logic                 rsat;
	logic [63:0]          rv;
	logic [63:0]          rres;
	logic [63:0]          r2;
	logic                 ge;
	logic                 qrnd;
	logic [NUMW:0]        qr;
	logic [31:0]          lim;
	logic                 qsat;
	logic [31:0]          qv;
	logic                 free;
	logic                 sing;
	logic                 load;
	logic [63:0]          cof_e;

	// operand fetch for the triple products and the determinant row
	assign fa    = mat_q[m4i_pkg::elem_addr(ent_q, term_q, 2'd0)];
	assign fb    = mat_q[m4i_pkg::elem_addr(ent_q, term_q, 2'd1)];
	assign fc    = mat_q[m4i_pkg::elem_addr(ent_q, term_q, 2'd2)];
	assign mrow  = mat_q[{2'b00, j_q}];
	assign cof_j = cof_q[{j_q, 2'b00}];
	assign cof_e = cof_q[ent_q];

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TERM: begin
				if (ph_q == 3'd0) begin
					mul_a = {fa[31], fa};
					mul_b = {fb[31], fb};
				end else if (ph_q == 3'd2) begin
					mul_a = {1'b0, pab_q[31:0]};
					mul_b = {fc[31], fc};
				end else begin
					mul_a = {pab_q[63], pab_q[63:32]};
					mul_b = {fc[31], fc};
				end
			end
			ST_DET: begin
				mul_a = {mrow[31], mrow};
				mul_b = (ph_q == 3'd0) ? {1'b0, cof_j[31:0]} : {cof_j[63], cof_j[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// accumulate low or high partial product
	assign sub = (state_q == ST_TERM) &&
		((term_q >= 3'd3) ^ ent_q[2] ^ ent_q[0]);
	always_comb begin
		if ((state_q == ST_TERM && ph_q == 3'd3) || (state_q == ST_DET && ph_q == 3'd1)) begin
			addend = {{64{mul_q[63]}}, mul_q};
		end else begin
			addend = {{32{mul_q[63]}}, mul_q, 32'd0};
		end
		acc_nx = sub ? acc_q - addend : acc_q + addend;
	end

	// round half away from zero, saturate to 64 bits
	always_comb begin
		rnd_t  = mag_q + (detm_q ? (128'd1 << (F - 1)) : (128'd1 << (2 * F - 1)));
		rnd_sh = detm_q ? (rnd_t >> F) : (rnd_t >> (2 * F));
		rsat   = |rnd_sh[127:63];
		rv     = rsat ? m4i_pkg::INT64_MAX : rnd_sh[63:0];
		rres   = neg_q ? (64'd0 - rv) : rv;
	end

	// restoring divider step and final rounding
	assign r2   = {rem_q[62:0], num_q[NUMW-1]};
	assign ge   = (r2 >= den_q);
	assign qrnd = ({rem_q, 1'b0} >= {1'b0, den_q});
	assign qr   = {1'b0, num_q} + (NUMW+1)'(qrnd);
	assign lim  = qneg_q ? m4i_pkg::NEG_LIM : m4i_pkg::POS_LIM;
	assign qsat = (qr > (NUMW+1)'(lim));
	assign qv   = qsat ? lim : qr[31:0];

	assign sing = (det_q == 64'sd0);
	assign free = !ovalid_q || res.ready;
	assign load = (state_q == ST_EMIT) && free;
	assign pop  = (state_q == ST_IDLE) && !empty;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ent_q    <= '0;
			term_q   <= '0;
			ph_q     <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			detm_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= ST_TERM;
						ent_q   <= '0;
						term_q  <= '0;
						ph_q    <= '0;
						detm_q  <= 1'b0;
					end
				end
				ST_TERM: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (term_q == 3'd5) begin
							term_q  <= '0;
							state_q <= ST_RND1;
						end else begin
							term_q <= term_q + 3'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_RND1: begin
					state_q <= ST_RND2;
				end
				ST_RND2: begin
					if (detm_q) begin
						ent_q   <= '0;
						state_q <= (rres == 64'd0) ? ST_EMIT : ST_DIVI;
					end else if (ent_q == m4i_pkg::LAST_IDX) begin
						j_q     <= '0;
						ph_q    <= '0;
						state_q <= ST_DET;
					end else begin
						ent_q   <= ent_q + 4'd1;
						state_q <= ST_TERM;
					end
				end
				ST_DET: begin
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (j_q == 2'd3) begin
							detm_q  <= 1'b1;
							state_q <= ST_RND1;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_DIVI: begin
					cnt_q   <= CNTW'(NUMW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (free) begin
						if (ent_q == m4i_pkg::LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							ent_q   <= ent_q + 4'd1;
							state_q <= sing ? ST_EMIT : ST_DIVI;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mat_q <= rd_data;
				acc_q <= '0;
			end
			ST_TERM: begin
				if (ph_q == 3'd1) begin
					pab_q <= mul_q;
				end else begin
					mul_q <= prod[63:0];
				end
				if (ph_q == 3'd3 || ph_q == 3'd4) begin
					acc_q <= acc_nx;
				end
			end
			ST_RND1: begin
				neg_q <= acc_q[127];
				mag_q <= acc_q[127] ? (128'd0 - acc_q) : acc_q;
			end
			ST_RND2: begin
				acc_q <= '0;
				if (detm_q) begin
					det_q  <= rres;
					dsat_q <= rsat;
				end else begin
					cof_q[ent_q]  <= rres;
					csat_q[ent_q] <= rsat;
				end
			end
			ST_DET: begin
				mul_q <= prod[63:0];
				if (ph_q != 3'd0) begin
					acc_q <= acc_nx;
				end
			end
			ST_DIVI: begin
				num_q  <= {(cof_e[63] ? (64'd0 - cof_e) : cof_e), F'(0)};
				den_q  <= det_q[63] ? (64'd0 - det_q) : det_q;
				qneg_q <= cof_e[63] ^ det_q[63];
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? (r2 - den_q) : r2;
				num_q <= {num_q[NUMW-2:0], ge};
			end
			ST_EMIT: begin
				if (free) begin
					oidx_q  <= ent_q;
					olast_q <= (ent_q == m4i_pkg::LAST_IDX);
					osing_q <= sing;
					if (sing) begin
						oval_q <= mat_q[ent_q];
						osat_q <= 1'b0;
					end else begin
						oval_q <= qneg_q ? (32'd0 - qv) : qv;
						osat_q <= csat_q[ent_q] | dsat_q | qsat;
					end
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign res.valid     = ovalid_q;
	assign res.out_index = oidx_q;
	assign res.out_value = oval_q;
	assign res.singular  = osing_q;
	assign res.saturated = osat_q;
	assign res.last      = olast_q;

	// checks
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ent_q == m4i_pkg::LAST_IDX) |=> (state_q == ST_IDLE))
		else $error("back did not return to idle after last result");
	a_sing_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && osing_q) |-> !osat_q)
		else $error("singular result flagged saturated");
	a_div_det: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (det_q != 64'sd0))
		else $error("division with zero determinant");

endmodule

>>> rtl/mat4_inverse_cofactor.sv
// mat4_inverse_cofactor: top level, 4x4 fixed-point matrix inverse.
// Depends on m4i_pkg, m4i_if, m4i_front, m4i_queue, m4i_back.

// Elements arrive one per transaction in row-major order (Q16.16) and are
// taken one per cycle while the snapshot queue is not full; the element with
// index 15 queues a snapshot of the matrix (two snapshots deep) and the
// compute side produces 16 results, index 0 to 15, the last one flagged. The
// compute side uses one shared 33x33 multiplier: each of the 16 adjugate
// entries takes 6 terms and then rounding (ST_RND1, ST_RND2), and the
// determinant follows from row 0 and its cofactors. For a regular matrix
// each inverse element then goes through a one-bit-per-cycle divider of
// 64+FRAC_BITS steps, giving a Q16.16 quotient. Elements of the next matrix
// are accepted meanwhile until the snapshot queue is full.
module mat4_inverse_cofactor (
	input  logic        clk,
	input  logic        arst_n,
	m4i_elem_if.sink    elem,
	m4i_res_if.source   res
);

	m4i_pkg::q_wr_t wr;
	m4i_pkg::mat_t  rd_data;
	logic           full;
	logic           empty;
	logic           pop;

	m4i_front u_front (
		.clk    (clk),
		.elem   (elem),
		.wr     (wr),
		.full   (full)
	);

	m4i_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.rd_data (rd_data)
	);

	m4i_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.rd_data (rd_data),
		.pop     (pop),
		.res     (res)
	);

endmodule
